FILE: rtl/cra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cra_pkg;

   // Operation codes
   localparam logic [3:0] OP_ADD   = 4'd0;
   localparam logic [3:0] OP_SUB   = 4'd1;
   localparam logic [3:0] OP_MUL   = 4'd2;
   localparam logic [3:0] OP_DIV   = 4'd3;
   localparam logic [3:0] OP_NEG   = 4'd4;
   localparam logic [3:0] OP_GT    = 4'd5;
   localparam logic [3:0] OP_EQ    = 4'd6;
   localparam logic [3:0] OP_FLOOR = 4'd7;
   localparam logic [3:0] OP_IQUO  = 4'd8;
   localparam logic [3:0] OP_IREM  = 4'd9;

   // Error codes
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_OVF  = 2'd1;
   localparam logic [1:0] ERR_DIVZ = 2'd2;

   localparam int QUEUE_DEPTH = 2;

   // Classified item as it travels from the front end to the back end
   typedef struct packed {
      logic [3:0]         op;
      logic signed [31:0] a_num;
      logic [30:0]        a_den;
      logic signed [31:0] b_num;
      logic [30:0]        b_den;
      logic               binary;
      logic [1:0]         err;
   } cra_item_type;

endpackage

`default_nettype wire

FILE: rtl/cra_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cra_front
   import cra_pkg::*;
(
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [3:0]         req_operation,
   input  wire logic signed [31:0] req_a_num,
   input  wire logic [30:0]        req_a_den,
   input  wire logic signed [31:0] req_b_num,
   input  wire logic [30:0]        req_b_den,
   input  wire logic               queue_full,
   output logic                    push,
   output cra_item_type            push_item
);

   logic binary;
   logic divz;

   always_comb begin
      binary = (req_operation inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_EQ});
      divz   = 1'b0;
      if (req_operation <= OP_FLOOR) begin
         // zero denominators read by the operation, or a zero divisor
         divz = (req_a_den == '0) || (binary && (req_b_den == '0)) ||
                ((req_operation == OP_DIV) && (req_b_num == '0));
      end else if (req_operation inside {OP_IQUO, OP_IREM}) begin
         divz = (req_b_num == '0);
      end
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item.op     = req_operation;
      push_item.a_num  = req_a_num;
      push_item.a_den  = req_a_den;
      push_item.b_num  = req_b_num;
      push_item.b_den  = req_b_den;
      push_item.binary = binary;
      push_item.err    = divz ? ERR_DIVZ : ERR_NONE;
   end

endmodule

`default_nettype wire

FILE: rtl/cra_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module cra_fifo
   import cra_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire cra_item_type push_item,
   output logic              full,
   input  wire logic         pop,
   output cra_item_type      pop_item,
   output logic              empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   cra_item_type        mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/cra_div.sv
`timescale 1ns / 1ps
`default_nettype none

module cra_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient,
   output logic [31:0]      remainder
);

   logic [31:0] quo_ff, rem_ff, dsr_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [32:0] shifted;
   logic [32:0] trial;

   // restoring division, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[31]};
   assign trial   = shifted - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd32;
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            if (!trial[32]) begin
               rem_ff <= trial[31:0];
               quo_ff <= {quo_ff[30:0], 1'b1};
            end else begin
               rem_ff <= shifted[31:0];
               quo_ff <= {quo_ff[30:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

FILE: rtl/cra_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cra_back
   import cra_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire cra_item_type       item,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_result_num,
   output logic [30:0]             rsp_result_den,
   output logic                    rsp_compare_flag,
   output logic [1:0]              rsp_error_code
);

   typedef enum logic [3:0] {
      S_IDLE, S_RED0, S_GCD, S_RDN, S_RDD, S_RFIX, S_OP, S_ADD,
      S_P1, S_P2, S_P3, S_P4, S_FLOOR, S_IDIV
   } state_type;

   typedef enum logic [1:0] {PH_A, PH_B, PH_R} phase_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      mag32 = v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic fits64(input logic signed [63:0] v);
      fits64 = (v[63:31] == {33{v[31]}});
   endfunction

   state_type          state_ff;
   phase_type          phase_ff;
   logic [3:0]         op_ff;
   logic               binary_ff;
   logic signed [31:0] an_ff, bn_ff;
   logic [30:0]        ad_ff, bd_ff;
   logic signed [31:0] red_n_ff, red_d_ff;
   logic [31:0]        u_ff, v_ff, mn_ff, md_ff, qn_ff, qd_ff;
   logic [4:0]         k_ff;
   logic               neg_ff;
   logic signed [31:0] p_ff, s_ff;
   logic signed [63:0] prod_ff;
   logic               div_go_ff;
   logic [31:0]        div_a_ff, div_b_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_num_ff;
   logic [30:0]        rsp_den_ff;
   logic               rsp_flag_ff;
   logic [1:0]         rsp_err_ff;

   logic               div_done;
   logic [31:0]        div_quo, div_rem;
   logic signed [31:0] mul_x, mul_y;
   logic signed [63:0] mul_p;
   logic               gcd_done;
   logic [31:0]        gcd_res;
   logic signed [31:0] rfix_n;
   logic               rfix_ovf;
   logic signed [32:0] sum_eq, sum_pq;
   logic signed [31:0] ad_s, bd_s;

   cra_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go_ff),
      .dividend  (div_a_ff),
      .divisor   (div_b_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign ad_s = signed'({1'b0, ad_ff});
   assign bd_s = signed'({1'b0, bd_ff});

   // shared multiplier operand selection; product lands in prod_ff next cycle
   always_comb begin
      case (state_ff)
         S_P1: begin
            mul_x = an_ff;
            mul_y = (op_ff == OP_MUL) ? bn_ff : bd_s;
         end
         S_P2: begin
            if (op_ff == OP_MUL) begin
               mul_x = ad_s;
               mul_y = bd_s;
            end else if (op_ff == OP_DIV) begin
               mul_x = ad_s;
               mul_y = bn_ff;
            end else begin
               mul_x = bn_ff;
               mul_y = ad_s;
            end
         end
         default: begin
            mul_x = ad_s;
            mul_y = bd_s;
         end
      endcase
   end

   assign mul_p = mul_x * mul_y;

   assign gcd_done = (u_ff == '0) || (v_ff == '0);
   assign gcd_res  = (u_ff == '0) ? (v_ff << k_ff) : (u_ff << k_ff);

   assign rfix_n   = neg_ff ? signed'(32'(-qn_ff)) : signed'(qn_ff);
   assign rfix_ovf = qd_ff[31] || (neg_ff ? (qn_ff > 32'h8000_0000) : qn_ff[31]);

   assign sum_eq = {an_ff[31], an_ff} + {bn_ff[31], bn_ff};
   assign sum_pq = {p_ff[31], p_ff} + {prod_ff[31], prod_ff[31:0]};

   assign pop = (state_ff == S_IDLE) && item_valid && !rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_A;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_go_ff <= 1'b0;
         prod_ff   <= mul_p;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  op_ff     <= item.op;
                  binary_ff <= item.binary;
                  an_ff     <= item.a_num;
                  ad_ff     <= item.a_den;
                  bn_ff     <= item.b_num;
                  bd_ff     <= item.b_den;
                  red_n_ff  <= item.a_num;
                  red_d_ff  <= signed'({1'b0, item.a_den});
                  phase_ff  <= PH_A;
                  if (item.err != ERR_NONE) begin
                     rsp_num_ff   <= '0;
                     rsp_den_ff   <= 31'd1;
                     rsp_flag_ff  <= 1'b0;
                     rsp_err_ff   <= item.err;
                     rsp_valid_ff <= 1'b1;
                  end else if (item.op <= OP_FLOOR) begin
                     state_ff <= S_RED0;
                  end else if (item.op inside {OP_IQUO, OP_IREM}) begin
                     div_go_ff <= 1'b1;
                     div_a_ff  <= mag32(item.a_num);
                     div_b_ff  <= mag32(item.b_num);
                     state_ff  <= S_IDIV;
                  end else begin
                     rsp_num_ff   <= '0;
                     rsp_den_ff   <= 31'd1;
                     rsp_flag_ff  <= 1'b0;
                     rsp_err_ff   <= ERR_NONE;
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            S_RED0: begin
               mn_ff    <= mag32(red_n_ff);
               md_ff    <= mag32(red_d_ff);
               u_ff     <= mag32(red_n_ff);
               v_ff     <= mag32(red_d_ff);
               k_ff     <= '0;
               neg_ff   <= red_n_ff[31] ^ red_d_ff[31];
               state_ff <= S_GCD;
            end
            S_GCD: begin
               // binary gcd, one step per cycle
               if (gcd_done) begin
                  if (gcd_res == 32'd1) begin
                     qn_ff    <= mn_ff;
                     qd_ff    <= md_ff;
                     state_ff <= S_RFIX;
                  end else begin
                     div_go_ff <= 1'b1;
                     div_a_ff  <= mn_ff;
                     div_b_ff  <= gcd_res;
                     state_ff  <= S_RDN;
                  end
               end else if (!u_ff[0] && !v_ff[0]) begin
                  u_ff <= u_ff >> 1;
                  v_ff <= v_ff >> 1;
                  k_ff <= k_ff + 1'b1;
               end else if (!u_ff[0]) begin
                  u_ff <= u_ff >> 1;
               end else if (!v_ff[0]) begin
                  v_ff <= v_ff >> 1;
               end else if (u_ff >= v_ff) begin
                  u_ff <= (u_ff - v_ff) >> 1;
               end else begin
                  v_ff <= (v_ff - u_ff) >> 1;
               end
            end
            S_RDN: begin
               if (div_done) begin
                  qn_ff     <= div_quo;
                  div_go_ff <= 1'b1;
                  div_a_ff  <= md_ff;
                  state_ff  <= S_RDD;
               end
            end
            S_RDD: begin
               if (div_done) begin
                  qd_ff    <= div_quo;
                  state_ff <= S_RFIX;
               end
            end
            S_RFIX: begin
               case (phase_ff)
                  PH_A: begin
                     an_ff <= rfix_n;
                     ad_ff <= qd_ff[30:0];
                     if (binary_ff) begin
                        red_n_ff <= bn_ff;
                        red_d_ff <= bd_s;
                        phase_ff <= PH_B;
                        state_ff <= S_RED0;
                     end else begin
                        state_ff <= S_OP;
                     end
                  end
                  PH_B: begin
                     bn_ff    <= rfix_n;
                     bd_ff    <= qd_ff[30:0];
                     state_ff <= S_OP;
                  end
                  default: begin
                     rsp_num_ff   <= rfix_ovf ? '0 : rfix_n;
                     rsp_den_ff   <= rfix_ovf ? 31'd1 : qd_ff[30:0];
                     rsp_flag_ff  <= 1'b0;
                     rsp_err_ff   <= rfix_ovf ? ERR_OVF : ERR_NONE;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
               endcase
            end
            S_OP: begin
               state_ff <= S_IDLE;
               case (op_ff)
                  OP_ADD: state_ff <= S_ADD;
                  OP_SUB: begin
                     if (bn_ff == 32'sh8000_0000) begin
                        rsp_num_ff   <= '0;
                        rsp_den_ff   <= 31'd1;
                        rsp_flag_ff  <= 1'b0;
                        rsp_err_ff   <= ERR_OVF;
                        rsp_valid_ff <= 1'b1;
                     end else begin
                        bn_ff    <= -bn_ff;
                        state_ff <= S_ADD;
                     end
                  end
                  OP_MUL, OP_DIV, OP_GT: state_ff <= S_P1;
                  OP_NEG: begin
                     rsp_num_ff   <= (an_ff == 32'sh8000_0000) ? '0 : -an_ff;
                     rsp_den_ff   <= (an_ff == 32'sh8000_0000) ? 31'd1 : ad_ff;
                     rsp_flag_ff  <= 1'b0;
                     rsp_err_ff   <= (an_ff == 32'sh8000_0000) ? ERR_OVF : ERR_NONE;
                     rsp_valid_ff <= 1'b1;
                  end
                  OP_EQ: begin
                     rsp_num_ff   <= '0;
                     rsp_den_ff   <= 31'd1;
                     rsp_flag_ff  <= (an_ff == bn_ff) && (ad_ff == bd_ff);
                     rsp_err_ff   <= ERR_NONE;
                     rsp_valid_ff <= 1'b1;
                  end
                  default: begin
                     div_go_ff <= 1'b1;
                     div_a_ff  <= mag32(an_ff);
                     div_b_ff  <= {1'b0, ad_ff};
                     state_ff  <= S_FLOOR;
                  end
               endcase
            end
            S_ADD: begin
               if (ad_ff == bd_ff) begin
                  if (sum_eq[32] != sum_eq[31]) begin
                     rsp_num_ff   <= '0;
                     rsp_den_ff   <= 31'd1;
                     rsp_flag_ff  <= 1'b0;
                     rsp_err_ff   <= ERR_OVF;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     red_n_ff <= sum_eq[31:0];
                     red_d_ff <= ad_s;
                     phase_ff <= PH_R;
                     state_ff <= S_RED0;
                  end
               end else begin
                  state_ff <= S_P1;
               end
            end
            S_P1: state_ff <= S_P2;
            S_P2: begin
               p_ff <= prod_ff[31:0];
               if (!fits64(prod_ff)) begin
                  rsp_num_ff   <= '0;
                  rsp_den_ff   <= 31'd1;
                  rsp_flag_ff  <= 1'b0;
                  rsp_err_ff   <= ERR_OVF;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  state_ff <= S_P3;
               end
            end
            S_P3: begin
               if (!fits64(prod_ff) ||
                   (((op_ff == OP_ADD) || (op_ff == OP_SUB)) && (sum_pq[32] != sum_pq[31]))) begin
                  rsp_num_ff   <= '0;
                  rsp_den_ff   <= 31'd1;
                  rsp_flag_ff  <= 1'b0;
                  rsp_err_ff   <= ERR_OVF;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else if (op_ff == OP_GT) begin
                  rsp_num_ff   <= '0;
                  rsp_den_ff   <= 31'd1;
                  rsp_flag_ff  <= (p_ff > signed'(prod_ff[31:0]));
                  rsp_err_ff   <= ERR_NONE;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else if ((op_ff == OP_MUL) || (op_ff == OP_DIV)) begin
                  red_n_ff <= p_ff;
                  red_d_ff <= prod_ff[31:0];
                  phase_ff <= PH_R;
                  state_ff <= S_RED0;
               end else begin
                  s_ff     <= sum_pq[31:0];
                  state_ff <= S_P4;
               end
            end
            S_P4: begin
               if (!fits64(prod_ff)) begin
                  rsp_num_ff   <= '0;
                  rsp_den_ff   <= 31'd1;
                  rsp_flag_ff  <= 1'b0;
                  rsp_err_ff   <= ERR_OVF;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  red_n_ff <= s_ff;
                  red_d_ff <= prod_ff[31:0];
                  phase_ff <= PH_R;
                  state_ff <= S_RED0;
               end
            end
            S_FLOOR: begin
               if (div_done) begin
                  // round toward minus infinity for negative numerators
                  rsp_num_ff   <= an_ff[31] ?
                                  signed'(32'(-div_quo) - {31'd0, (div_rem != '0)}) :
                                  signed'(div_quo);
                  rsp_den_ff   <= 31'd1;
                  rsp_flag_ff  <= 1'b0;
                  rsp_err_ff   <= ERR_NONE;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_IDIV: begin
               if (div_done) begin
                  rsp_den_ff   <= 31'd1;
                  rsp_flag_ff  <= 1'b0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
                  if (op_ff == OP_IREM) begin
                     rsp_num_ff <= an_ff[31] ? signed'(32'(-div_rem)) : signed'(div_rem);
                     rsp_err_ff <= ERR_NONE;
                  end else if (!(an_ff[31] ^ bn_ff[31]) && div_quo[31]) begin
                     rsp_num_ff <= '0;
                     rsp_err_ff <= ERR_OVF;
                  end else begin
                     rsp_num_ff <= (an_ff[31] ^ bn_ff[31]) ? signed'(32'(-div_quo)) :
                                   signed'(div_quo);
                     rsp_err_ff <= ERR_NONE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_num   = rsp_num_ff;
   assign rsp_result_den   = rsp_den_ff;
   assign rsp_compare_flag = rsp_flag_ff;
   assign rsp_error_code   = rsp_err_ff;

endmodule

`default_nettype wire

FILE: rtl/checked_rational_alu.sv
// Checked rational arithmetic unit.
// Request channel (req_*): one item carries an operation code and two rationals
// a_num/a_den and b_num/b_den with 31-bit positive denominators.
// Response channel (rsp_*): exactly one item per request, in request order,
// holding a reduced numerator/denominator, a compare flag and an error code
// (overflow or division by zero; on error the result reads 0/1, flag 0).
// A front end classifies each item (division-by-zero checks) and parks it in a
// two-entry queue; a back end carries it out with one 32x32 multiplier, a
// binary gcd stepper and a shared radix-2 divider.
// Division by zero and undefined codes are answered directly at the queue head;
// integer quotient and remainder take one pass of the divider. Every other
// operation reduces by gcd: a binary gcd loop, then, unless the gcd is 1, two
// divides. Negate and floor reduce one operand, equality two, greater two plus
// two products, and add, subtract, multiply and divide also reduce the result.
// The back end takes a new item only once it has finished the last one and
// that item's response has been taken.
// Reset (synchronous, active high) empties the queue and drops any item in work.
// A stalled receiver holds the response; the queue still takes up to two more
// items before req_ready falls.
`timescale 1ns / 1ps
`default_nettype none

module checked_rational_alu
   import cra_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [3:0]         req_operation,
   input  wire logic signed [31:0] req_a_num,
   input  wire logic [30:0]        req_a_den,
   input  wire logic signed [31:0] req_b_num,
   input  wire logic [30:0]        req_b_den,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_result_num,
   output logic [30:0]             rsp_result_den,
   output logic                    rsp_compare_flag,
   output logic [1:0]              rsp_error_code
);

   logic         queue_full, queue_empty;
   logic         push, pop;
   cra_item_type push_item, pop_item;

   // classify and hand over to the queue
   cra_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_a_num     (req_a_num),
      .req_a_den     (req_a_den),
      .req_b_num     (req_b_num),
      .req_b_den     (req_b_den),
      .queue_full    (queue_full),
      .push          (push),
      .push_item     (push_item)
   );

   // decouple intake from the long-running back end
   cra_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (queue_empty)
   );

   // execute one item at a time and hold its result until taken
   cra_back u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (!queue_empty),
      .item             (pop_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_num   (rsp_result_num),
      .rsp_result_den   (rsp_result_den),
      .rsp_compare_flag (rsp_compare_flag),
      .rsp_error_code   (rsp_error_code)
   );

endmodule

`default_nettype wire

FILE: rtl/cra_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cra_checker
   import cra_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [31:0] rsp_result_num,
   input wire logic [30:0]        rsp_result_den,
   input wire logic               rsp_compare_flag,
   input wire logic [1:0]         rsp_error_code
);

   // hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_num) &&
      $stable(rsp_result_den) && $stable(rsp_compare_flag) && $stable(rsp_error_code))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != ERR_NONE) |->
      (rsp_result_num == 0) && (rsp_result_den == 31'd1) && !rsp_compare_flag)
      else $error("error response carries a value");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_flag |->
      (rsp_result_num == 0) && (rsp_result_den == 31'd1) && (rsp_error_code == ERR_NONE))
      else $error("compare flag set with a value");

   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("response pending straight after reset");

endmodule

bind checked_rational_alu cra_checker u_cra_checker (.*);

`default_nettype wire
